>>> rtl/core/pcd_pkg.sv
package pcd_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_ASSIGN  = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_TICK    = 2'd3
   } cmd_type;

   // Event codes carried on rsp_tuser
   typedef enum logic [2:0] {
      EV_QUEUED     = 3'd0,
      EV_DROPPED    = 3'd1,
      EV_STARTED    = 3'd2,
      EV_COMPLETED  = 3'd3,
      EV_TERMINATED = 3'd4,
      EV_IDLE       = 3'd5,
      EV_INVALID    = 3'd6,
      EV_NOTHING    = 3'd7
   } event_type;

   // Sequencer states of the back end
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_RELEASE,
      ST_TICK,
      ST_ASSIGN,
      ST_FINISH
   } state_type;

   localparam int unsigned MAX_RESULTS = 16;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [23:0] TIME_MAX = 24'hFFFFFF;

   // Classified request passed from front to back
   typedef struct packed {
      cmd_type     cmd;
      logic [1:0]  prio;
      logic [7:0]  dur;
      logic [3:0]  num;
   } job_req_type;

   // One result item
   typedef struct packed {
      event_type   event_code;
      logic [3:0]  agent_index;
      logic [15:0] call_number;
      logic [1:0]  call_priority;
      logic [15:0] calls_done;
      logic [23:0] time_total;
      logic [4:0]  queue_fill;
   } rsp_type;

   // Queue control from the sequencer
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [1:0] prio;
   } queue_ctrl_type;

endpackage

>>> rtl/core/pcd_front.sv
module pcd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  logic [15:0]          req_tdata,
   output logic                 job_valid,
   input  logic                 job_pop,
   output pcd_pkg::job_req_type job_req
);

   pcd_pkg::job_req_type slot_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           fill_ff, fill_in;
   logic                 push;
   pcd_pkg::job_req_type decoded;

   // Classify the incoming request
   always_comb begin
      decoded.cmd  = pcd_pkg::cmd_type'(req_tuser);
      decoded.prio = req_tdata[1:0];
      decoded.dur  = req_tdata[9:2];
      decoded.num  = req_tdata[13:10];
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign job_valid  = (fill_ff != 2'd0);
   assign job_req    = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> rtl/core/pcd_queue.sv
module pcd_queue #(
   parameter int DEPTH = 16,
   parameter int DW    = 8,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pcd_pkg::queue_ctrl_type ctrl,
   input  logic [15:0]             push_job,
   input  logic [DW-1:0]           push_dur,
   output logic [CW-1:0]           count,
   output logic                    full,
   output logic [15:0]             front_job,
   output logic [1:0]              front_prio,
   output logic [DW-1:0]           front_dur
);

   logic [15:0]   job_ff  [DEPTH];
   logic [1:0]    prio_ff [DEPTH];
   logic [DW-1:0] dur_ff  [DEPTH];
   logic [15:0]   job_in  [DEPTH];
   logic [1:0]    prio_in [DEPTH];
   logic [DW-1:0] dur_in  [DEPTH];
   logic [DEPTH-1:0] keep;
   logic [CW-1:0] count_ff, count_in;

   assign count      = count_ff;
   assign full       = (count_ff == CW'(DEPTH));
   assign front_job  = job_ff[0];
   assign front_prio = prio_ff[0];
   assign front_dur  = dur_ff[0];

   // Entries ahead of the new job stay; sorted order makes this a prefix
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         keep[k] = (CW'(k) < count_ff) && (prio_ff[k] <= ctrl.prio);
      end
   end

   // Insert after equal or higher priority, shifting later entries back, or on pop shift toward the front
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         job_in[k]  = job_ff[k];
         prio_in[k] = prio_ff[k];
         dur_in[k]  = dur_ff[k];
         if (ctrl.push && !keep[k]) begin
            if (k == 0 || keep[(k == 0) ? 0 : k - 1]) begin
               job_in[k]  = push_job;
               prio_in[k] = ctrl.prio;
               dur_in[k]  = push_dur;
            end else begin
               job_in[k]  = job_ff[(k == 0) ? 0 : k - 1];
               prio_in[k] = prio_ff[(k == 0) ? 0 : k - 1];
               dur_in[k]  = dur_ff[(k == 0) ? 0 : k - 1];
            end
         end else if (ctrl.pop && k < DEPTH - 1) begin
            job_in[k]  = job_ff[(k < DEPTH - 1) ? k + 1 : k];
            prio_in[k] = prio_ff[(k < DEPTH - 1) ? k + 1 : k];
            dur_in[k]  = dur_ff[(k < DEPTH - 1) ? k + 1 : k];
         end
      end
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         job_ff[k]  <= job_in[k];
         prio_ff[k] <= prio_in[k];
         dur_ff[k]  <= dur_in[k];
      end
   end

endmodule

>>> rtl/core/pcd_back.sv
module pcd_back #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int AGENTS_MAX    = 8,
   parameter int DURATION_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           srv_limit,
   input  logic                 job_valid,
   output logic                 job_pop,
   input  pcd_pkg::job_req_type job_req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pcd_pkg::rsp_type     rsp,
   output logic                 rsp_last
);

   localparam int AW = (AGENTS_MAX > 1) ? $clog2(AGENTS_MAX) : 1;
   localparam int IW = AW + 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = DURATION_BITS;

   pcd_pkg::state_type   state_ff, state_in;
   pcd_pkg::job_req_type cur_ff, cur_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 any_ff, any_in;
   logic [4:0]           nres_ff, nres_in;
   logic                 hold_valid_ff, hold_valid_in;
   pcd_pkg::rsp_type     hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pcd_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 last_ff, last_in;
   logic [15:0]          next_id_ff, next_id_in;

   logic          busy_ff  [AGENTS_MAX];
   logic [15:0]   job_ff   [AGENTS_MAX];
   logic [DW-1:0] rem_ff   [AGENTS_MAX];
   logic [DW-1:0] dur_ff   [AGENTS_MAX];
   logic [15:0]   done_ff  [AGENTS_MAX];
   logic [23:0]   sum_ff   [AGENTS_MAX];
   logic          busy_in  [AGENTS_MAX];
   logic [15:0]   job_in   [AGENTS_MAX];
   logic [DW-1:0] rem_in   [AGENTS_MAX];
   logic [DW-1:0] dur_in   [AGENTS_MAX];
   logic [15:0]   done_in  [AGENTS_MAX];
   logic [23:0]   sum_in   [AGENTS_MAX];

   pcd_pkg::queue_ctrl_type qctrl;
   logic [CW-1:0] q_count;
   logic          q_full;
   logic [15:0]   q_job;
   logic [1:0]    q_prio;
   logic [DW-1:0] q_dur;

   logic [4:0]       used;
   logic [AW-1:0]    ix;
   logic             scan_done;
   logic             out_free;
   logic             emit;
   pcd_pkg::rsp_type new_rsp;
   logic [24:0]      sum_wide;
   logic [15:0]      done_next;
   logic [23:0]      sum_next;
   logic [3:0]       agent_num;
   logic [4:0]       rel_ix;

   pcd_queue #(
      .DEPTH (QUEUE_DEPTH),
      .DW    (DW),
      .CW    (CW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (qctrl),
      .push_job   (next_id_ff),
      .push_dur   (DW'(cur_ff.dur)),
      .count      (q_count),
      .full       (q_full),
      .front_job  (q_job),
      .front_prio (q_prio),
      .front_dur  (q_dur)
   );

   assign used      = (5'(srv_limit) > 5'(AGENTS_MAX)) ? 5'(AGENTS_MAX) : 5'(srv_limit);
   assign ix        = idx_ff[AW-1:0];
   assign scan_done = (5'(idx_ff) >= used);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign agent_num = 4'(idx_ff) + 4'd1;
   assign rel_ix    = 5'(cur_ff.num) - 5'd1;

   // Completion credit for the scanned server, both saturating
   always_comb begin
      sum_wide  = {1'b0, sum_ff[ix]} + 25'(dur_ff[ix]);
      sum_next  = sum_wide[24] ? pcd_pkg::TIME_MAX : sum_wide[23:0];
      done_next = (done_ff[ix] == pcd_pkg::COUNT_MAX) ? done_ff[ix]
                                                       : done_ff[ix] + 16'd1;
   end

   // Sequencer: next state, server updates and result emission
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      any_in        = any_ff;
      nres_in       = nres_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      last_in       = last_ff;
      next_id_in    = next_id_ff;
      job_pop       = 1'b0;
      qctrl         = '{push: 1'b0, pop: 1'b0, prio: cur_ff.prio};
      emit          = 1'b0;
      new_rsp       = '0;
      new_rsp.queue_fill = 5'(q_count);
      for (int a = 0; a < AGENTS_MAX; a++) begin
         busy_in[a] = busy_ff[a];
         job_in[a]  = job_ff[a];
         rem_in[a]  = rem_ff[a];
         dur_in[a]  = dur_ff[a];
         done_in[a] = done_ff[a];
         sum_in[a]  = sum_ff[a];
      end

      unique case (state_ff)
         pcd_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               cur_in  = job_req;
               idx_in  = '0;
               any_in  = 1'b0;
               nres_in = '0;
               unique case (job_req.cmd)
                  pcd_pkg::CMD_ADD:     state_in = pcd_pkg::ST_ADD;
                  pcd_pkg::CMD_ASSIGN:  state_in = pcd_pkg::ST_ASSIGN;
                  pcd_pkg::CMD_RELEASE: state_in = pcd_pkg::ST_RELEASE;
                  pcd_pkg::CMD_TICK:    state_in = pcd_pkg::ST_TICK;
                  default:              state_in = pcd_pkg::ST_IDLE;
               endcase
            end
         end
         pcd_pkg::ST_ADD: begin
            if (!hold_valid_ff || out_free) begin
               emit = 1'b1;
               new_rsp.call_priority = cur_ff.prio;
               if (q_full) begin
                  new_rsp.event_code = pcd_pkg::EV_DROPPED;
               end else begin
                  qctrl.push = 1'b1;
                  new_rsp.event_code  = pcd_pkg::EV_QUEUED;
                  new_rsp.call_number = next_id_ff;
                  new_rsp.queue_fill  = 5'(q_count + CW'(1));
                  next_id_in = next_id_ff + 16'd1;
               end
               state_in = pcd_pkg::ST_FINISH;
            end
         end
         pcd_pkg::ST_RELEASE: begin
            if (!hold_valid_ff || out_free) begin
               emit = 1'b1;
               if (cur_ff.num == 4'd0 || 5'(cur_ff.num) > used) begin
                  new_rsp.event_code = pcd_pkg::EV_INVALID;
               end else begin
                  new_rsp.agent_index = cur_ff.num;
                  new_rsp.calls_done  = done_ff[rel_ix[AW-1:0]];
                  new_rsp.time_total  = sum_ff[rel_ix[AW-1:0]];
                  if (busy_ff[rel_ix[AW-1:0]]) begin
                     new_rsp.event_code  = pcd_pkg::EV_TERMINATED;
                     new_rsp.call_number = job_ff[rel_ix[AW-1:0]];
                     busy_in[rel_ix[AW-1:0]] = 1'b0;
                     rem_in[rel_ix[AW-1:0]]  = '0;
                     job_in[rel_ix[AW-1:0]]  = '0;
                  end else begin
                     new_rsp.event_code = pcd_pkg::EV_IDLE;
                  end
               end
               state_in = pcd_pkg::ST_FINISH;
            end
         end
         pcd_pkg::ST_TICK: begin
            if (scan_done) begin
               idx_in   = '0;
               state_in = any_ff ? pcd_pkg::ST_ASSIGN : pcd_pkg::ST_FINISH;
            end else if (!busy_ff[ix]) begin
               idx_in = idx_ff + IW'(1);
            end else if (rem_ff[ix] > DW'(1)) begin
               rem_in[ix] = rem_ff[ix] - DW'(1);
               idx_in     = idx_ff + IW'(1);
            end else if (!hold_valid_ff || out_free) begin
               emit        = 1'b1;
               done_in[ix] = done_next;
               sum_in[ix]  = sum_next;
               busy_in[ix] = 1'b0;
               rem_in[ix]  = '0;
               job_in[ix]  = '0;
               any_in      = 1'b1;
               new_rsp.event_code  = pcd_pkg::EV_COMPLETED;
               new_rsp.agent_index = agent_num;
               new_rsp.call_number = job_ff[ix];
               new_rsp.calls_done  = done_next;
               new_rsp.time_total  = sum_next;
               idx_in = idx_ff + IW'(1);
            end
         end
         pcd_pkg::ST_ASSIGN: begin
            if (scan_done) begin
               state_in = pcd_pkg::ST_FINISH;
            end else if (busy_ff[ix] || q_count == '0) begin
               idx_in = idx_ff + IW'(1);
            end else if (!hold_valid_ff || out_free) begin
               emit        = 1'b1;
               qctrl.pop   = 1'b1;
               busy_in[ix] = 1'b1;
               job_in[ix]  = q_job;
               rem_in[ix]  = q_dur;
               dur_in[ix]  = q_dur;
               new_rsp.event_code    = pcd_pkg::EV_STARTED;
               new_rsp.agent_index   = agent_num;
               new_rsp.call_number   = q_job;
               new_rsp.call_priority = q_prio;
               new_rsp.calls_done    = done_ff[ix];
               new_rsp.time_total    = sum_ff[ix];
               new_rsp.queue_fill    = 5'(q_count - CW'(1));
               idx_in = idx_ff + IW'(1);
            end
         end
         pcd_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               if (hold_valid_ff) begin
                  rsp_in        = hold_ff;
                  hold_valid_in = 1'b0;
               end else begin
                  rsp_in = new_rsp;
                  rsp_in.event_code = pcd_pkg::EV_NOTHING;
               end
               state_in = pcd_pkg::ST_IDLE;
            end
         end
         default: state_in = pcd_pkg::ST_IDLE;
      endcase

      // Keep one result in hold so the final one can be marked
      if (emit && nres_ff < 5'(pcd_pkg::MAX_RESULTS)) begin
         nres_in       = nres_ff + 5'd1;
         hold_in       = new_rsp;
         hold_valid_in = 1'b1;
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = hold_ff;
            last_in      = 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign rsp_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcd_pkg::ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         next_id_ff    <= 16'd1;
         for (int a = 0; a < AGENTS_MAX; a++) begin
            busy_ff[a] <= 1'b0;
            job_ff[a]  <= '0;
            rem_ff[a]  <= '0;
            dur_ff[a]  <= '0;
            done_ff[a] <= '0;
            sum_ff[a]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         next_id_ff    <= next_id_in;
         for (int a = 0; a < AGENTS_MAX; a++) begin
            busy_ff[a] <= busy_in[a];
            job_ff[a]  <= job_in[a];
            rem_ff[a]  <= rem_in[a];
            dur_ff[a]  <= dur_in[a];
            done_ff[a] <= done_in[a];
            sum_ff[a]  <= sum_in[a];
         end
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      any_ff  <= any_in;
      nres_ff <= nres_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
      last_ff <= last_in;
   end

endmodule

>>> rtl/core/priority_call_dispatcher.sv
// The back end takes add or release straight to its final result; assign scans the
// servers, and tick scans them and then scans again for assign if a call completed, the
// back end checking one server per cycle unless an rsp_tready stall holds it.
// One request at a time in the back end; a 2-entry request queue
// lets the front take requests meanwhile. Reset: synchronous, active high;
// queue empty, all servers idle with zero totals, next job number 1, five servers in use.
module priority_call_dispatcher #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int AGENTS_MAX    = 8,
   parameter int DURATION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [15:0] req_tdata,   // priority_level, call_duration, agent_number
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // last_result
   output logic [2:0]  rsp_tuser,   // event_code
   output logic [71:0] rsp_tdata,   // agent_index, call_number, call_priority,
                                    // agent_calls_done, agent_time_total, queue_fill
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0]           srv_limit_ff, srv_limit_in;
   logic                 job_valid;
   logic                 job_pop;
   pcd_pkg::job_req_type job_req;
   pcd_pkg::rsp_type     rsp;

   // Register write and read
   assign csr_pready = 1'b1;
   always_comb begin
      srv_limit_in = srv_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         srv_limit_in = csr_pwdata[3:0];
      end
      csr_prdata = csr_paddr[2] ? 32'd0 : {28'd0, srv_limit_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srv_limit_ff <= 4'd5;
      end else begin
         srv_limit_ff <= srv_limit_in;
      end
   end

   pcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .job_req    (job_req)
   );

   pcd_back #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .AGENTS_MAX    (AGENTS_MAX),
      .DURATION_BITS (DURATION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .srv_limit   (srv_limit_ff),
      .job_valid   (job_valid),
      .job_pop     (job_pop),
      .job_req     (job_req),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp),
      .rsp_last    (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tuser = rsp.event_code;
   assign rsp_tdata = {5'd0, rsp.queue_fill, rsp.time_total, rsp.calls_done,
                       rsp.call_priority, rsp.call_number, rsp.agent_index};

endmodule

>>> tb/sv/priority_call_dispatcher_checker.sv
`timescale 1ns / 1ps

module priority_call_dispatcher_checker #(
   parameter int QUEUE_DEPTH = 16,
   parameter int AGENTS_MAX  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        rsp_tlast,
   input  logic [2:0]  rsp_tuser,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct {
      pcd_pkg::event_type ev;
      logic [3:0]  agent;
      logic [15:0] call;
      logic [1:0]  prio;
      logic [15:0] done;
      logic [23:0] tsum;
      logic [4:0]  fill;
      logic        last;
   } dispatch_event_type;

   dispatch_event_type event_q[$];

   // Mirror of the dispatcher state
   logic [15:0] wait_job[QUEUE_DEPTH];
   logic [1:0]  wait_prio[QUEUE_DEPTH];
   logic [7:0]  wait_dur[QUEUE_DEPTH];
   int          wait_cnt;
   logic [15:0] job_counter;
   logic        srv_busy[AGENTS_MAX];
   logic [15:0] srv_job[AGENTS_MAX];
   logic [7:0]  srv_left[AGENTS_MAX];
   logic [7:0]  srv_dur[AGENTS_MAX];
   logic [15:0] srv_done[AGENTS_MAX];
   logic [23:0] srv_time[AGENTS_MAX];
   logic [3:0]  agent_cfg;

   function automatic int agents_active();
      return (int'(agent_cfg) > AGENTS_MAX) ? AGENTS_MAX : int'(agent_cfg);
   endfunction

   function automatic void push_event(pcd_pkg::event_type ev, int agent, logic [15:0] call,
                                      logic [1:0] prio, logic [15:0] done,
                                      logic [23:0] tsum);
      dispatch_event_type e;
      e.ev = ev;
      e.agent = agent[3:0];
      e.call = call;
      e.prio = prio;
      e.done = done;
      e.tsum = tsum;
      e.fill = wait_cnt[4:0];
      e.last = 1'b0;
      event_q.push_back(e);
   endfunction

   // Hand the queue front to each idle server in index order
   function automatic int dispatch_idle();
      int n;
      n = 0;
      for (int i = 0; i < agents_active(); i++) begin
         if (srv_busy[i] || wait_cnt == 0) continue;
         srv_busy[i] = 1'b1;
         srv_job[i] = wait_job[0];
         srv_left[i] = wait_dur[0];
         srv_dur[i] = wait_dur[0];
         push_event(pcd_pkg::EV_STARTED, i + 1, wait_job[0], wait_prio[0], srv_done[i],
                    srv_time[i]);
         for (int k = 1; k < wait_cnt; k++) begin
            wait_job[k - 1] = wait_job[k];
            wait_prio[k - 1] = wait_prio[k];
            wait_dur[k - 1] = wait_dur[k];
         end
         wait_cnt--;
         event_q[$].fill = wait_cnt[4:0];
         n++;
      end
      return n;
   endfunction

   function automatic void predict_request(pcd_pkg::cmd_type cmd, logic [1:0] prio,
                                           logic [7:0] dur, logic [3:0] num);
      int n, pos, idx;
      logic [24:0] sum;
      n = 0;
      case (cmd)
         pcd_pkg::CMD_ADD: begin
            if (wait_cnt >= QUEUE_DEPTH) begin
               push_event(pcd_pkg::EV_DROPPED, 0, 16'd0, prio, 16'd0, 24'd0);
            end else begin
               pos = 0;
               while (pos < wait_cnt && wait_prio[pos] <= prio) pos++;
               for (int k = wait_cnt; k > pos; k--) begin
                  wait_job[k] = wait_job[k - 1];
                  wait_prio[k] = wait_prio[k - 1];
                  wait_dur[k] = wait_dur[k - 1];
               end
               wait_job[pos] = job_counter;
               wait_prio[pos] = prio;
               wait_dur[pos] = dur;
               wait_cnt++;
               push_event(pcd_pkg::EV_QUEUED, 0, job_counter, prio, 16'd0, 24'd0);
               job_counter = job_counter + 16'd1;
            end
            n = 1;
         end
         pcd_pkg::CMD_ASSIGN: n = dispatch_idle();
         pcd_pkg::CMD_RELEASE: begin
            if (int'(num) < 1 || int'(num) > agents_active()) begin
               push_event(pcd_pkg::EV_INVALID, 0, 16'd0, 2'd0, 16'd0, 24'd0);
            end else begin
               idx = int'(num) - 1;
               if (srv_busy[idx]) begin
                  push_event(pcd_pkg::EV_TERMINATED, int'(num), srv_job[idx], 2'd0,
                             srv_done[idx], srv_time[idx]);
                  srv_busy[idx] = 1'b0;
                  srv_left[idx] = 8'd0;
                  srv_job[idx] = 16'd0;
               end else begin
                  push_event(pcd_pkg::EV_IDLE, int'(num), 16'd0, 2'd0, srv_done[idx],
                             srv_time[idx]);
               end
            end
            n = 1;
         end
         default: begin
            // count down busy servers, credit the finished ones, then refill
            for (int i = 0; i < agents_active(); i++) begin
               if (!srv_busy[i]) continue;
               if (srv_left[i] > 1) begin
                  srv_left[i]--;
                  continue;
               end
               if (srv_done[i] != pcd_pkg::COUNT_MAX) srv_done[i]++;
               sum = srv_time[i] + srv_dur[i];
               srv_time[i] = (sum > pcd_pkg::TIME_MAX) ? pcd_pkg::TIME_MAX : sum[23:0];
               push_event(pcd_pkg::EV_COMPLETED, i + 1, srv_job[i], 2'd0, srv_done[i],
                          srv_time[i]);
               srv_busy[i] = 1'b0;
               srv_left[i] = 8'd0;
               srv_job[i] = 16'd0;
               n++;
            end
            if (n > 0) n += dispatch_idle();
         end
      endcase
      if (n == 0) push_event(pcd_pkg::EV_NOTHING, 0, 16'd0, 2'd0, 16'd0, 24'd0);
      event_q[$].last = 1'b1;
   endfunction

   function automatic void check_result();
      dispatch_event_type e, a;
      a.ev = pcd_pkg::event_type'(rsp_tuser);
      a.agent = rsp_tdata[3:0];
      a.call = rsp_tdata[19:4];
      a.prio = rsp_tdata[21:20];
      a.done = rsp_tdata[37:22];
      a.tsum = rsp_tdata[61:38];
      a.fill = rsp_tdata[66:62];
      a.last = rsp_tlast;
      result_count++;
      if (event_q.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: unexpected result ev=%0d agent=%0d call=%0d", $realtime,
                     a.ev, a.agent, a.call);
         return;
      end
      e = event_q.pop_front();
      if (e.ev !== a.ev || e.agent !== a.agent || e.call !== a.call || e.prio !== a.prio ||
          e.done !== a.done || e.tsum !== a.tsum || e.fill !== a.fill ||
          e.last !== a.last) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: mismatch exp ev=%0d agent=%0d call=%0d prio=%0d done=%0d",
                     $realtime, e.ev, e.agent, e.call, e.prio, e.done);
            $display("   time=%0d fill=%0d last=%0d", e.tsum, e.fill, e.last);
            $display("   got ev=%0d agent=%0d call=%0d prio=%0d done=%0d time=%0d",
                     a.ev, a.agent, a.call, a.prio, a.done, a.tsum);
            $display("   fill=%0d last=%0d", a.fill, a.last);
         end
      end
   endfunction

   initial begin
      error_count = 0;
      pending_count = 0;
      result_count = 0;
   end

   // Track config writes, check results, then predict each accepted request
   always @(posedge clock) begin
      if (reset) begin
         event_q.delete();
         wait_cnt = 0;
         job_counter = 16'd1;
         agent_cfg = 4'd5;
         for (int i = 0; i < AGENTS_MAX; i++) begin
            srv_busy[i] = 1'b0;
            srv_job[i] = '0;
            srv_left[i] = '0;
            srv_dur[i] = '0;
            srv_done[i] = '0;
            srv_time[i] = '0;
         end
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2])
            agent_cfg = csr_pwdata[3:0];
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready)
            predict_request(pcd_pkg::cmd_type'(req_tuser), req_tdata[1:0], req_tdata[9:2],
                            req_tdata[13:10]);
      end
      pending_count = event_q.size();
   end

endmodule

>>> tb/sv/priority_call_dispatcher_tb.sv
`timescale 1ns / 1ps

module priority_call_dispatcher_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // cmd
   logic [15:0] req_tdata;   // priority_level, call_duration, agent_number
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        rsp_tlast;   // last_result
   logic [2:0]  rsp_tuser;   // event_code
   logic [71:0] rsp_tdata;   // agent_index, call_number, call_priority,
                             // agent_calls_done, agent_time_total, queue_fill
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int error_count, pending_count, result_count;
   int request_count;
   int burst_left;
   bit gaps_on;
   bit stalls_on;

   priority_call_dispatcher dut (.*);

   priority_call_dispatcher_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tlast, .rsp_tuser, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .error_count, .pending_count, .result_count
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Receiver stall pattern: runs of ready and runs of stall
   int stall_run;
   always @(posedge clock) begin
      if (!stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_run == 0) begin
         stall_run <= $urandom_range(1, 7);
         rsp_tready <= ($urandom_range(0, 2) != 0);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   task automatic send_request(pcd_pkg::cmd_type cmd, logic [1:0] prio, logic [7:0] dur,
                               logic [3:0] num);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {2'b00, num, dur, prio};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      request_count++;
   endtask

   task automatic write_srv_limit(logic [31:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'd0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Mostly short jobs so completions are frequent, a few long ones
   task automatic random_request();
      int pick;
      logic [7:0] dur;
      logic [3:0] num;
      pick = $urandom_range(0, 99);
      dur = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      num = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
      if (pick < 40)
         send_request(pcd_pkg::CMD_ADD, 2'($urandom), dur, num);
      else if (pick < 58)
         send_request(pcd_pkg::CMD_ASSIGN, 2'($urandom), dur, num);
      else if (pick < 72)
         send_request(pcd_pkg::CMD_RELEASE, 2'($urandom), dur, num);
      else
         send_request(pcd_pkg::CMD_TICK, 2'($urandom), dur, num);
   endtask

   initial begin
      logic [31:0] settings[6];
      settings = '{32'd8, 32'd1, 32'd0, 32'd15, 32'd3, 32'd8};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stall_run = 0;
      burst_left = 0;
      request_count = 0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bad release numbers, idle server, empty assign and tick
      send_request(pcd_pkg::CMD_RELEASE, 2'd0, 8'd0, 4'd0);
      send_request(pcd_pkg::CMD_RELEASE, 2'd3, 8'hFF, 4'd15);
      send_request(pcd_pkg::CMD_RELEASE, 2'd0, 8'd0, 4'd1);
      send_request(pcd_pkg::CMD_ASSIGN, 2'd0, 8'd0, 4'd0);
      send_request(pcd_pkg::CMD_TICK, 2'd0, 8'd0, 4'd0);
      // Priority ordering with equal levels, zero and maximum durations
      send_request(pcd_pkg::CMD_ADD, 2'd3, 8'd255, 4'd0);
      send_request(pcd_pkg::CMD_ADD, 2'd0, 8'd0, 4'd0);
      send_request(pcd_pkg::CMD_ADD, 2'd2, 8'd1, 4'd0);
      send_request(pcd_pkg::CMD_ADD, 2'd1, 8'd2, 4'd0);
      send_request(pcd_pkg::CMD_ADD, 2'd0, 8'd3, 4'd0);
      send_request(pcd_pkg::CMD_ASSIGN, 2'd0, 8'd0, 4'd0);
      send_request(pcd_pkg::CMD_TICK, 2'd0, 8'd0, 4'd0);
      send_request(pcd_pkg::CMD_RELEASE, 2'd0, 8'd0, 4'd5);
      send_request(pcd_pkg::CMD_RELEASE, 2'd0, 8'd0, 4'd2);
      // Fill the queue and overflow it by one
      for (int i = 0; i < 17; i++)
         send_request(pcd_pkg::CMD_ADD, 2'($urandom), 8'($urandom_range(0, 3)),
                      4'($urandom));

      // Random phases, one per server limit setting, with idling on both sides
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      foreach (settings[s]) begin
         write_srv_limit(settings[s]);
         for (int i = 0; i < 30; i++) random_request();
      end
      req_tvalid <= 1'b0;

      // Drain, then give the back end time to show any stray result
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d requests and %0d results over server limits 5 8 1 0 15 3 8",
               request_count, result_count);
      $display("including queue overflow, zero-length jobs and bad release numbers");
      if (error_count == 0 && pending_count == 0) begin
         $display("priority_call_dispatcher_tb: done, clean");
      end else begin
         $display("priority_call_dispatcher_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("priority_call_dispatcher_tb: done, errors");
      $finish;
   end

endmodule
